FILE: src/msng_pkg.sv
// shared types, constants and the quarter-wave sine table of the signal generator
package msng_pkg;

  localparam int SINE_INDEX_BITS = 10;
  localparam int CHANNEL_COUNT   = 4;
  localparam int NUM_LANES       = 4;
  localparam int SAMPLE_W        = 16;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int SEED_W          = 32;
  localparam int ACC_W           = 32;
  localparam int CNT_W           = 32;
  localparam int NOISE_W         = 11;
  localparam int QUARTER         = 1 << (SINE_INDEX_BITS - 2);
  localparam int QIDX_W          = SINE_INDEX_BITS - 1;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = 2;
  localparam int QCNT_W          = QPTR_W + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DC_LEVELS     = 3'd0,
    REG_AMPLITUDES    = 3'd1,
    REG_FREQ_LOW_PAIR = 3'd2,
    REG_FREQ_HIGH_PAIR = 3'd3,
    REG_PHASE_OFFSETS = 3'd4,
    REG_NOISE_LEVELS  = 3'd5,
    REG_NOISE_SEED    = 3'd6
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [NOISE_W-1:0]  noise_t;
  typedef logic [SINE_INDEX_BITS-1:0] phase_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] dc_levels;
    logic [CFG_W-1:0] amplitudes;
    logic [CFG_W-1:0] freq_lo;
    logic [CFG_W-1:0] freq_hi;
    logic [CFG_W-1:0] phase_offsets;
    logic [CFG_W-1:0] noise_levels;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [SEED_W-1:0] value;
  } seed_load_t;

  // one classified sample handed from the front to the back
  typedef struct packed {
    logic [CNT_W-1:0]                 index;
    phase_idx_t [NUM_LANES-1:0]       phase;
    noise_t [NUM_LANES-1:0]           centred;
  } front_item_t;

  typedef logic [SAMPLE_W-1:0] qsine_tab_t [QUARTER+1];

  // quarter-wave table, odd taylor series in q30 scaled to q15
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t  tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t3;
    logic [63:0] t5;
    logic [63:0] t7;
    logic [63:0] t9;
    logic [63:0] r;
    logic [63:0] q;
    for (int k = 0; k <= QUARTER; k++) begin
      x  = (64'(k) * HALF_PI_Q30) >> (SINE_INDEX_BITS - 2);
      x2 = (x * x) >> 30;
      t3 = ((x * x2) >> 30) / 64'd6;
      t5 = ((t3 * x2) >> 30) / 64'd20;
      t7 = ((t5 * x2) >> 30) / 64'd42;
      t9 = ((t7 * x2) >> 30) / 64'd72;
      r  = x + t5 + t9 - t3 - t7;
      q  = (r * 64'd32767 + 64'd536870912) >> 30;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = q[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE_TAB = build_qsine();

endpackage

FILE: src/msng_front.sv
// front end: accepts ticks, steps counter, phase accumulators and noise generator
module msng_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  msng_pkg::cfg_t          cfg,
  input  msng_pkg::seed_load_t    seed_ld,
  input  logic                    push,
  input  logic                    restart,
  input  logic                    q_full,
  output logic                    q_wr,
  output msng_pkg::front_item_t   q_item
);
  import msng_pkg::*;

  localparam logic [9:0] NOISE_CENTRE = 10'd510;

  logic [ACC_W-1:0]  acc_r   [NUM_LANES];
  logic [ACC_W-1:0]  acc_nxt [NUM_LANES];
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [SEED_W-1:0] noise_r;
  logic [SEED_W-1:0] noise_nxt;
  logic [SEED_W-1:0] noise_chain;
  logic [CNT_W-1:0]  cnt_base;
  logic              accept;

  function automatic logic [SEED_W-1:0] xs_step(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  assign accept   = push && !q_full;
  assign q_wr     = accept;
  assign cnt_base = restart ? '0 : cnt_r;
  assign cnt_nxt  = accept ? cnt_base + 1'b1 : cnt_r;

  always_comb begin
    logic [ACC_W-1:0]  base;
    logic [ACC_W-1:0]  phase;
    logic [ACC_W-1:0]  freq;
    logic [SEED_W-1:0] x;
    logic [9:0]        bsum;
    x = noise_r;
    q_item.index = cnt_base;
    for (int c = 0; c < NUM_LANES; c++) begin
      base  = restart ? '0 : acc_r[c];
      phase = base + {cfg.phase_offsets[16*c +: 16], 16'h0000};
      freq  = (c < 2) ? cfg.freq_lo[32*(c%2) +: 32] : cfg.freq_hi[32*(c%2) +: 32];
      q_item.phase[c]   = phase[ACC_W-1 -: SINE_INDEX_BITS];
      q_item.centred[c] = '0;
      acc_nxt[c]        = acc_r[c];
      if (c < CHANNEL_COUNT) begin
        // channels draw noise in ascending order
        x    = xs_step(x);
        bsum = 10'(x[7:0]) + 10'(x[15:8]) + 10'(x[23:16]) + 10'(x[31:24]);
        q_item.centred[c] = noise_t'($signed({1'b0, bsum}) - $signed({1'b0, NOISE_CENTRE}));
        if (accept) begin
          acc_nxt[c] = base + freq;
        end
      end
    end
    noise_chain = x;
  end

  always_comb begin
    noise_nxt = noise_r;
    if (seed_ld.load) begin
      noise_nxt = (seed_ld.value == '0) ? SEED_W'(1) : seed_ld.value;
    end else if (accept) begin
      noise_nxt = noise_chain;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      noise_r <= SEED_W'(1);
      for (int c = 0; c < NUM_LANES; c++) begin
        acc_r[c] <= '0;
      end
    end else begin
      cnt_r   <= cnt_nxt;
      noise_r <= noise_nxt;
      for (int c = 0; c < NUM_LANES; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
    end
  end

endmodule

FILE: src/msng_fifo.sv
// short queue decoupling the front end from the arithmetic back end
module msng_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  msng_pkg::front_item_t   wr_data,
  output logic                    full,
  input  logic                    rd_en,
  output logic                    rd_valid,
  output msng_pkg::front_item_t   rd_data
);
  import msng_pkg::*;

  front_item_t       mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: src/msng_back.sv
// back end: sine lookup, amplitude and noise scaling, sum and saturation
module msng_back (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  msng_pkg::cfg_t                              cfg,
  input  logic                                        in_valid,
  input  msng_pkg::front_item_t                       in_item,
  output logic                                        in_take,
  output logic                                        out_valid,
  input  logic                                        out_pop,
  output logic [msng_pkg::CNT_W-1:0]                  out_index,
  output msng_pkg::sample_t [msng_pkg::NUM_LANES-1:0] out_value
);
  import msng_pkg::*;

  // stage 1: table lookup
  logic                        s1_v_r;
  logic                        s1_v_nxt;
  logic [CNT_W-1:0]            s1_idx_r;
  sample_t [NUM_LANES-1:0]     s1_sine_r;
  noise_t [NUM_LANES-1:0]      s1_cent_r;
  sample_t [NUM_LANES-1:0]     sine_nxt;
  // stage 2: products
  logic                        s2_v_r;
  logic                        s2_v_nxt;
  logic [CNT_W-1:0]            s2_idx_r;
  logic signed [31:0]          s2_sprod_r [NUM_LANES];
  logic signed [27:0]          s2_nprod_r [NUM_LANES];
  // stage 3: result register
  logic                        s3_v_r;
  logic                        s3_v_nxt;
  logic [CNT_W-1:0]            s3_idx_r;
  sample_t [NUM_LANES-1:0]     s3_val_r;
  sample_t [NUM_LANES-1:0]     val_nxt;

  logic s1_rdy;
  logic s2_rdy;
  logic s3_rdy;

  assign s3_rdy   = !s3_v_r || out_pop;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_take  = in_valid && s1_rdy;
  assign s1_v_nxt = s1_rdy ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_rdy ? s1_v_r : s2_v_r;
  assign s3_v_nxt = s3_rdy ? s2_v_r : s3_v_r;

  assign out_valid = s3_v_r;
  assign out_index = s3_idx_r;
  assign out_value = s3_val_r;

  always_comb begin
    logic [1:0]                 quad;
    logic [QIDX_W-1:0]          k;
    logic [SAMPLE_W-1:0]        q;
    for (int c = 0; c < NUM_LANES; c++) begin
      quad = in_item.phase[c][SINE_INDEX_BITS-1 -: 2];
      k    = {1'b0, in_item.phase[c][SINE_INDEX_BITS-3:0]};
      // odd quadrants run the quarter wave backwards
      if (quad[0]) begin
        k = QIDX_W'(QUARTER) - k;
      end
      q = QSINE_TAB[k];
      sine_nxt[c] = quad[1] ? -$signed(q) : $signed(q);
    end
  end

  always_comb begin
    logic signed [31:0] srnd;
    logic signed [16:0] sterm;
    logic signed [19:0] nterm;
    logic signed [20:0] total;
    for (int c = 0; c < NUM_LANES; c++) begin
      srnd  = s2_sprod_r[c] + 32'sd16384;
      sterm = 17'(srnd >>> 15);
      nterm = 20'(s2_nprod_r[c] >>> 7);
      total = 21'($signed(cfg.dc_levels[16*c +: 16])) + 21'(sterm) + 21'(nterm);
      if (c >= CHANNEL_COUNT) begin
        val_nxt[c] = '0;
      end else if (total > 21'sd32767) begin
        val_nxt[c] = 16'sh7FFF;
      end else if (total < -21'sd32768) begin
        val_nxt[c] = 16'sh8000;
      end else begin
        val_nxt[c] = total[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_idx_r  <= in_item.index;
      s1_sine_r <= sine_nxt;
      s1_cent_r <= in_item.centred;
    end
    if (s2_rdy && s1_v_r) begin
      s2_idx_r <= s1_idx_r;
      for (int c = 0; c < NUM_LANES; c++) begin
        s2_sprod_r[c] <= 32'($signed(cfg.amplitudes[16*c +: 16])) * 32'(s1_sine_r[c]);
        s2_nprod_r[c] <= 28'(s1_cent_r[c]) *
                         28'($signed({1'b0, cfg.noise_levels[16*c +: 16]}));
      end
    end
    if (s3_rdy && s2_v_r) begin
      s3_idx_r <= s2_idx_r;
      s3_val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

endmodule

FILE: src/multichannel_sine_noise_generator.sv
// four-channel sine plus noise test source: config registers and block wiring
// a taken tick passes through the queue and the three back stages before its result shows
// throughput: one sample per cycle while the output is popped, set by the three-stage back pipeline
//   (table lookup, multiply, sum and saturate) behind a 4-entry queue
// in_full rises only after the queue holds 4 ticks while the output is not popped
// reset (synchronous, rst_n low): accumulators and counter to 0, noise state to 1,
//   config registers to 0, queue and pipeline emptied; their data registers are not reset
module multichannel_sine_noise_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_restart,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [msng_pkg::CNT_W-1:0]      out_sample_index,
  output logic signed [15:0]              out_chan0_value,
  output logic signed [15:0]              out_chan1_value,
  output logic signed [15:0]              out_chan2_value,
  output logic signed [15:0]              out_chan3_value,
  input  logic                            cfg_we,
  input  logic [msng_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msng_pkg::CFG_W-1:0]      cfg_data
);
  import msng_pkg::*;

  cfg_t                    cfg_r;
  cfg_t                    cfg_nxt;
  seed_load_t              seed_ld;
  logic                    q_wr;
  logic                    q_full;
  front_item_t             q_wr_item;
  logic                    q_valid;
  front_item_t             q_rd_item;
  logic                    q_take;
  logic                    out_valid;
  sample_t [NUM_LANES-1:0] out_value;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DC_LEVELS:      cfg_nxt.dc_levels     = cfg_data;
        REG_AMPLITUDES:     cfg_nxt.amplitudes    = cfg_data;
        REG_FREQ_LOW_PAIR:  cfg_nxt.freq_lo       = cfg_data;
        REG_FREQ_HIGH_PAIR: cfg_nxt.freq_hi       = cfg_data;
        REG_PHASE_OFFSETS:  cfg_nxt.phase_offsets = cfg_data;
        REG_NOISE_LEVELS:   cfg_nxt.noise_levels  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign seed_ld.load  = cfg_we && (cfg_reg_t'(cfg_index) == REG_NOISE_SEED);
  assign seed_ld.value = cfg_data[SEED_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msng_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .seed_ld (seed_ld),
    .push    (in_push),
    .restart (in_restart),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_item  (q_wr_item)
  );

  msng_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_wr_item),
    .full     (q_full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_rd_item)
  );

  msng_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (q_valid),
    .in_item   (q_rd_item),
    .in_take   (q_take),
    .out_valid (out_valid),
    .out_pop   (out_pop),
    .out_index (out_sample_index),
    .out_value (out_value)
  );

  assign in_full         = q_full;
  assign out_empty       = !out_valid;
  assign out_chan0_value = out_value[0];
  assign out_chan1_value = out_value[1];
  assign out_chan2_value = out_value[2];
  assign out_chan3_value = out_value[3];

endmodule

FILE: src/msng_checker.sv
// port-level checks for the signal generator, bound to the top level
module msng_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [31:0]        out_sample_index,
  input logic signed [15:0] out_chan0_value,
  input logic signed [15:0] out_chan1_value,
  input logic signed [15:0] out_chan2_value,
  input logic signed [15:0] out_chan3_value
);

  // reset leaves nothing queued and nothing to transfer
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queue or output not cleared by reset");

  // the queue only fills while a finished result is held back
  a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full with no result waiting");

  // with no output transfer nothing drains from a full queue
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_full && !out_pop |=> in_full)
    else $error("full queue drained without an output transfer");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_sample_index)
      && $stable(out_chan0_value) && $stable(out_chan1_value)
      && $stable(out_chan2_value) && $stable(out_chan3_value))
    else $error("waiting result changed before its transfer");

endmodule

bind multichannel_sine_noise_generator msng_checker u_msng_checker (.*);
